/* hw/rtl/sct_pkg.sv */
package sct_pkg;

    // Opcode values
    localparam logic OP_SINE   = 1'b0;
    localparam logic OP_COSINE = 1'b1;

    // Datapath widths
    localparam int RW  = 40;  // angle magnitude in Q32, then reduced angle
    localparam int TW  = 42;  // series term and intermediate quotient, Q32
    localparam int PPW = 64;  // partial products
    localparam int SW  = 42;  // signed accumulator, Q32

    localparam logic [34:0]   TWO_PI_Q32 = 35'h6487ED511;
    localparam logic [TW-1:0] ONE_Q32    = TW'(64'h1_0000_0000);
    localparam int            MSCALE     = 42;  // reciprocal scale 2^MSCALE

    localparam logic signed [SW-1:0] SUM_POS_ONE = SW'(64'sh1_0000_0000);
    localparam logic signed [SW-1:0] SUM_NEG_ONE = -SW'(64'sh1_0000_0000);
    localparam logic signed [31:0]   VAL_POS_ONE = 32'sh4000_0000;
    localparam logic signed [31:0]   VAL_NEG_ONE = -32'sh4000_0000;

    typedef struct packed {
        logic                 cos;
        logic                 neg;
        logic [RW-1:0]        r;
        logic [TW-1:0]        term;
        logic [TW-1:0]        prod;
        logic [PPW-1:0]       pl;
        logic [PPW-1:0]       ph;
        logic signed [SW-1:0] sum;
    } stage_t;

endpackage

/* hw/rtl/sine_cosine_taylor_series_core.sv */
// Sine / cosine by truncated Taylor series.
//
// Input channel: req_valid / req_stall carry opcode (0 sine, 1 cosine) and
// angle (signed Q8.24 radians). Output channel: rsp_valid / rsp_stall carry
// value (signed Q2.30, saturated to +/-1.0). The series length comes from
// cfg_wr_data, written while cfg_wr_en is high; reset loads 14 terms.
//
// The angle is reduced modulo 2*pi in five compare-subtract stages, then each
// series term takes ten stages: two multiply-by-angle steps, each followed by
// a reciprocal-multiply divide by the matching factorial factor.
// Throughput: one item per cycle while the receiver does not stall, set by the
// fully unrolled pipeline.
//
// Reset empties the pipeline and the output register. While the receiver
// stalls, the pipeline still advances and new items are taken until the last
// stage holds an item behind the waiting result; then the whole pipeline
// holds and req_stall rises.
module sine_cosine_taylor_series_core #(
    parameter int MAX_TERMS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic        opcode,
    input  logic [31:0] angle,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [31:0] value
);

    localparam int NSTAGE = 10 * MAX_TERMS - 2;
    localparam int NTW    = $clog2(MAX_TERMS + 1);
    localparam int BLK0   = 6;
    localparam int ACC    = BLK0 + 10 * (MAX_TERMS - 1);
    localparam int LAST   = NSTAGE - 1;

    logic [4:0]            series_terms_reg;
    logic [NSTAGE-1:0]     vld_reg;
    sct_pkg::stage_t       data_reg  [NSTAGE];
    sct_pkg::stage_t       data_next [NSTAGE];
    logic [NTW-1:0]        nterms_reg [NSTAGE];
    logic [NTW-1:0]        nterms_next;
    logic                  rsp_valid_reg;
    logic [31:0]           value_reg;
    logic [31:0]           value_next;
    logic                  out_free;
    logic                  adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            series_terms_reg <= 5'd14;
        end
        else if (cfg_wr_en)
        begin
            series_terms_reg <= cfg_wr_data;
        end
    end

    // Clamp the term count into 1..MAX_TERMS
    always_comb
    begin
        if (series_terms_reg == 5'd0)
        begin
            nterms_next = NTW'(1);
        end
        else if ({1'b0, series_terms_reg} > 6'(MAX_TERMS))
        begin
            nterms_next = NTW'(MAX_TERMS);
        end
        else
        begin
            nterms_next = NTW'(series_terms_reg);
        end
    end

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign adv       = out_free || !vld_reg[LAST];
    assign req_stall = !adv;

    for (genvar g = 0; g < NSTAGE; g++)
    begin : g_stage
        if (g == 0)
        begin : g_capture
            logic [31:0] mag;
            always_comb
            begin
                mag = angle[31] ? (32'd0 - angle) : angle;
                data_next[g]      = '0;
                data_next[g].cos  = (opcode == sct_pkg::OP_COSINE);
                data_next[g].neg  = angle[31];
                data_next[g].r    = {mag, 8'b0};
            end
        end
        else if (g <= 5)
        begin : g_reduce
            localparam logic [sct_pkg::RW-1:0] CMUL =
                sct_pkg::RW'(sct_pkg::TWO_PI_Q32) << (5 - g);
            logic [sct_pkg::RW-1:0] rm;
            always_comb
            begin
                rm = (data_reg[g-1].r >= CMUL) ? (data_reg[g-1].r - CMUL) : data_reg[g-1].r;
                data_next[g]   = data_reg[g-1];
                data_next[g].r = rm;
                if (g == 5)
                begin
                    data_next[g].term = data_reg[g-1].cos ? sct_pkg::ONE_Q32
                                                          : sct_pkg::TW'(rm);
                end
            end
        end
        else if (g < ACC)
        begin : g_term
            localparam int N     = (g - BLK0) / 10;
            localparam int H     = ((g - BLK0) % 10) / 5;
            localparam int J     = (g - BLK0) % 5;
            localparam int D_SIN = 2 * N + 2 + H;
            localparam int D_COS = 2 * N + 1 + H;
            localparam logic [63:0] M_SIN = (64'd1 << sct_pkg::MSCALE) / 64'(D_SIN);
            localparam logic [63:0] M_COS = (64'd1 << sct_pkg::MSCALE) / 64'(D_COS);

            if (J == 0)
            begin : g_mul
                logic [54:0] plo;
                logic [54:0] phi;
                always_comb
                begin
                    plo = data_reg[g-1].term[19:0] * data_reg[g-1].r[34:0];
                    phi = data_reg[g-1].term[39:20] * data_reg[g-1].r[34:0];
                    data_next[g]    = data_reg[g-1];
                    data_next[g].pl = 64'(plo);
                    data_next[g].ph = 64'(phi);
                    // add the current term, alternating sign, while in range
                    if (H == 0 && NTW'(N) < nterms_reg[g-1])
                    begin
                        if ((N % 2) == 0)
                        begin
                            data_next[g].sum = data_reg[g-1].sum + $signed(data_reg[g-1].term);
                        end
                        else
                        begin
                            data_next[g].sum = data_reg[g-1].sum - $signed(data_reg[g-1].term);
                        end
                    end
                end
            end
            else if (J == 1)
            begin : g_mulsum
                logic [75:0] acc;
                always_comb
                begin
                    acc = {data_reg[g-1].ph[55:0], 20'b0} + 76'(data_reg[g-1].pl[54:0]);
                    data_next[g]      = data_reg[g-1];
                    data_next[g].prod = acc[73:32];
                end
            end
            else if (J == 2)
            begin : g_dmul
                logic [42:0] m;
                logic [63:0] plo;
                logic [63:0] phi;
                always_comb
                begin
                    m   = data_reg[g-1].cos ? M_COS[42:0] : M_SIN[42:0];
                    plo = data_reg[g-1].prod[20:0] * m;
                    phi = data_reg[g-1].prod[41:21] * m;
                    data_next[g]    = data_reg[g-1];
                    data_next[g].pl = plo;
                    data_next[g].ph = phi;
                end
            end
            else if (J == 3)
            begin : g_dsum
                logic [84:0] acc;
                always_comb
                begin
                    acc = {data_reg[g-1].ph, 21'b0} + 85'(data_reg[g-1].pl);
                    data_next[g]      = data_reg[g-1];
                    data_next[g].term = acc[83:42];
                end
            end
            else
            begin : g_dfix
                logic [6:0]  d;
                logic [48:0] qd;
                logic [41:0] rem;
                always_comb
                begin
                    d   = data_reg[g-1].cos ? 7'(D_COS) : 7'(D_SIN);
                    qd  = data_reg[g-1].term * d;
                    rem = data_reg[g-1].prod - qd[41:0];
                    data_next[g] = data_reg[g-1];
                    // the reciprocal estimate is at most one low
                    if (rem >= 42'(d))
                    begin
                        data_next[g].term = data_reg[g-1].term + 42'd1;
                    end
                end
            end
        end
        else if (g == ACC)
        begin : g_acc
            always_comb
            begin
                data_next[g] = data_reg[g-1];
                if (NTW'(MAX_TERMS - 1) < nterms_reg[g-1])
                begin
                    if (((MAX_TERMS - 1) % 2) == 0)
                    begin
                        data_next[g].sum = data_reg[g-1].sum + $signed(data_reg[g-1].term);
                    end
                    else
                    begin
                        data_next[g].sum = data_reg[g-1].sum - $signed(data_reg[g-1].term);
                    end
                end
            end
        end
        else
        begin : g_sign
            always_comb
            begin
                data_next[g] = data_reg[g-1];
                // sine is odd: flip for a negative angle
                if (!data_reg[g-1].cos && data_reg[g-1].neg)
                begin
                    data_next[g].sum = -data_reg[g-1].sum;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NSTAGE-2:0], req_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nterms_reg[0] <= nterms_next;
            for (int i = 0; i < NSTAGE; i++)
            begin
                data_reg[i] <= data_next[i];
            end
            for (int i = 1; i < NSTAGE; i++)
            begin
                nterms_reg[i] <= nterms_reg[i-1];
            end
        end
    end

    // Saturate, else round half up from Q32 to Q2.30
    logic signed [sct_pkg::SW-1:0] rnd;
    always_comb
    begin
        rnd = data_reg[LAST].sum + sct_pkg::SW'(2);
        if (data_reg[LAST].sum >= sct_pkg::SUM_POS_ONE)
        begin
            value_next = sct_pkg::VAL_POS_ONE;
        end
        else if (data_reg[LAST].sum <= sct_pkg::SUM_NEG_ONE)
        begin
            value_next = sct_pkg::VAL_NEG_ONE;
        end
        else
        begin
            value_next = rnd[33:2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            rsp_valid_reg <= vld_reg[LAST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            value_reg <= value_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign value     = value_reg;

    a_hold_full : assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall && vld_reg[LAST]) |-> req_stall)
        else $error("pipeline advanced into a stalled output");

    a_reduced : assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[5] |-> (data_reg[5].r < sct_pkg::RW'(sct_pkg::TWO_PI_Q32)))
        else $error("angle reduction left a remainder of 2*pi or more");

    a_range : assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ($signed(value) <= sct_pkg::VAL_POS_ONE &&
                       $signed(value) >= sct_pkg::VAL_NEG_ONE))
        else $error("result outside +/-1.0");

    a_bubble_move : assert property (@(posedge clk) disable iff (!rst_n)
        !vld_reg[LAST] |-> !req_stall)
        else $error("input stalled with an empty last stage");

endmodule

/* verif/tb_sine_cosine_taylor_series_core.sv */
`timescale 1ns / 100ps

module tb_sine_cosine_taylor_series_core;

    localparam int MAX_TERMS   = 16;
    localparam int LATENCY     = 10 * MAX_TERMS - 2;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_RANDOM    = 950;
    localparam logic [4:0] TERMS_RESET = 5'd14;

    localparam logic [63:0] TWO_PI_FIX = 64'h6_487E_D511;
    localparam logic [63:0] ONE_FIX    = 64'h1_0000_0000;

    typedef struct {
        logic        op;
        logic [31:0] ang;
        logic        known;
        logic [31:0] val;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [4:0]  cfg_wr_data = '0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    logic        opcode = sct_pkg::OP_SINE;
    logic [31:0] angle = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    logic [31:0] value;

    logic [4:0]  terms_cfg = TERMS_RESET;
    logic [31:0] expected_values[$];
    int          fail_count = 0;
    int          cycle_count = 0;
    bit          quiet_mode = 1'b0;
    stim_row_t   directed_rows[$];

    sine_cosine_taylor_series_core #(.MAX_TERMS(MAX_TERMS)) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .opcode(opcode),
        .angle(angle),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .value(value)
    );

    always #4 clk = ~clk;

    // floor(a*b / 2^32), wrapping to 64 bits
    function automatic logic [63:0] fix_mul(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[95:32];
    endfunction

    function automatic logic [31:0] taylor_value(logic op, logic [31:0] ang, logic [4:0] cfg);
        logic        neg;
        logic [63:0] mag;
        logic [63:0] red;
        logic [63:0] term;
        logic [63:0] pw;
        logic [63:0] biased;
        logic signed [63:0] sum;
        int          nt;
        nt  = (cfg == 0) ? 1 : ((cfg > MAX_TERMS) ? MAX_TERMS : int'(cfg));
        neg = ang[31];
        mag = neg ? (64'h1_0000_0000 - {32'd0, ang}) : {32'd0, ang};
        red = (mag << 8) % TWO_PI_FIX;
        term = (op == sct_pkg::OP_COSINE) ? ONE_FIX : red;
        pw   = (op == sct_pkg::OP_COSINE) ? 64'd0 : 64'd1;
        sum  = 0;
        for (int n = 0; n < nt; n++)
        begin
            if (n % 2 == 0)
                sum += $signed(term);
            else
                sum -= $signed(term);
            term = fix_mul(term, red) / (pw + 1);
            term = fix_mul(term, red) / (pw + 2);
            pw += 2;
        end
        if (op == sct_pkg::OP_SINE && neg)
            sum = -sum;
        if (sum >= $signed(ONE_FIX))
            return sct_pkg::VAL_POS_ONE;
        if (sum <= -$signed(ONE_FIX))
            return sct_pkg::VAL_NEG_ONE;
        biased = sum + 2 + (64'sd1 <<< 34);
        return 32'((biased >> 2) - (64'd1 << 32));
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** sine_cosine_taylor_series_core: FAILED **");
            $finish;
        end
    end

    // check every accepted result item
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_values.size() == 0)
            begin
                $error("value: expected none, actual %h", value);
                fail_count++;
            end
            else
            begin
                if (value !== expected_values[0])
                begin
                    $error("value: expected %h, actual %h", expected_values[0], value);
                    fail_count++;
                end
                void'(expected_values.pop_front());
            end
        end
    end

    // receiver stall in random bursts
    initial
    begin
        int burst;
        forever
        begin
            @(negedge clk);
            if (!quiet_mode && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 13);
                rsp_stall <= 1'b1;
                repeat (burst) @(negedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    task automatic send_item(logic op, logic [31:0] ang, bit idle_ok);
        int gap;
        if (idle_ok && !quiet_mode && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 13);
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        opcode    <= op;
        angle     <= ang;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        expected_values.push_back(taylor_value(op, ang, terms_cfg));
        @(negedge clk);
    endtask

    task automatic drain_and_write(logic [4:0] cfg);
        req_valid <= 1'b0;
        while (expected_values.size() != 0)
            @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cfg;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        terms_cfg = cfg;
    endtask

    function automatic void add_row(logic op, logic [31:0] ang, logic known, logic [31:0] val);
        stim_row_t r;
        r.op = op; r.ang = ang; r.known = known; r.val = val;
        directed_rows.push_back(r);
    endfunction

    function automatic logic [31:0] rand_angle();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 32'h0C00_0000)) - 32'sh0600_0000);
            2: return 32'h0648_7ED5 * $urandom_range(0, 40) + $urandom_range(0, 3) - 1;
            default: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom())};
        endcase
    endfunction

    initial
    begin
        logic [4:0] phase_cfg[6];
        int         per_phase;
        phase_cfg = '{5'd1, 5'd0, 5'd31, 5'd16, 5'd3, TERMS_RESET};

        // sin(0)=0, cos(0)=1 read off at a glance
        add_row(sct_pkg::OP_SINE,   32'h0000_0000, 1'b1, 32'h0000_0000);
        add_row(sct_pkg::OP_COSINE, 32'h0000_0000, 1'b1, sct_pkg::VAL_POS_ONE);
        add_row(sct_pkg::OP_SINE,   32'h7FFF_FFFF, 1'b0, '0);
        add_row(sct_pkg::OP_COSINE, 32'h7FFF_FFFF, 1'b0, '0);
        add_row(sct_pkg::OP_SINE,   32'h8000_0000, 1'b0, '0);
        add_row(sct_pkg::OP_COSINE, 32'h8000_0000, 1'b0, '0);
        add_row(sct_pkg::OP_SINE,   32'hFFFF_FFFF, 1'b0, '0);
        add_row(sct_pkg::OP_SINE,   32'h0000_0001, 1'b0, '0);
        add_row(sct_pkg::OP_COSINE, 32'h0648_7ED5, 1'b0, '0);   // about 2*pi
        add_row(sct_pkg::OP_SINE,   32'h0192_1FB5, 1'b0, '0);   // about pi/2
        add_row(sct_pkg::OP_SINE,   32'hFE6D_E04B, 1'b0, '0);   // about -pi/2
        add_row(sct_pkg::OP_COSINE, 32'h0324_3F6A, 1'b0, '0);   // about pi
        add_row(sct_pkg::OP_SINE,   32'h0C90_FDAA, 1'b0, '0);   // about 4*pi
        add_row(sct_pkg::OP_COSINE, 32'h5555_5555, 1'b0, '0);
        add_row(sct_pkg::OP_SINE,   32'hAAAA_AAAA, 1'b0, '0);

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            send_item(directed_rows[i].op, directed_rows[i].ang, 1'b0);
            if (directed_rows[i].known
                && expected_values[$] !== directed_rows[i].val)
            begin
                $error("value: expected %h, actual predicted %h",
                       directed_rows[i].val, expected_values[$]);
                fail_count++;
            end
        end

        per_phase = N_RANDOM / 6;
        foreach (phase_cfg[p])
        begin
            drain_and_write(phase_cfg[p]);
            if (p == 5)
                quiet_mode = 1'b1;
            for (int i = 0; i < per_phase; i++)
                send_item(1'($urandom_range(0, 1)), rand_angle(), 1'b1);
        end

        req_valid <= 1'b0;
        while (expected_values.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);

        if (fail_count == 0)
            $display("** sine_cosine_taylor_series_core: PASSED **");
        else
            $display("** sine_cosine_taylor_series_core: FAILED **");
        $finish;
    end

endmodule
